// ----- hw/rtl/dfpb_pkg.sv -----
// Shared types, widths, register codes and small helpers for the depth fog blender.
// Used by depth_fog_pixel_blend; depends on nothing.

package dfpb_pkg;

    // Field widths
    localparam int DEPTH_W     = 24;
    localparam int CHAN_W      = 6;
    localparam int NUM_CHAN    = 8;
    localparam int FOG_CH_W    = 5;
    localparam int FOG_COLOR_W = 20;
    localparam int OFFSET_W    = 15;
    localparam int SHIFT_W     = 4;

    // Density table geometry
    localparam int DENS_W       = 7;
    localparam int DENS_ENTRIES = 32;
    localparam int DENS_IDX_W   = 5;
    localparam int DENS_PER_REG = 8;
    localparam int DENS_REGS    = DENS_ENTRIES / DENS_PER_REG;
    localparam int DENS_ALL_W   = DENS_W * DENS_ENTRIES;
    localparam int DENS_POS_W   = 8;
    localparam int FRAC_W       = 10;
    localparam int DEPTH_SCALE  = 9;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DENS_W * DENS_PER_REG;

    // Alpha sits in lane 3 of each four-channel color
    localparam logic [1:0] ALPHA_LANE = 2'd3;

    // Pipeline depth
    localparam int NUM_STAGES = 6;

    typedef logic [CHAN_W-1:0]               t_chan;
    typedef t_chan [NUM_CHAN-1:0]            t_chan_arr;
    typedef logic [DENS_W-1:0]               t_dens;
    typedef logic [DENS_IDX_W-1:0]           t_dens_idx;
    typedef logic [FRAC_W-1:0]               t_frac;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOG_COLOR    = 3'd0,
        CFG_DEPTH_OFFSET = 3'd1,
        CFG_DEPTH_SHIFT  = 3'd2,
        CFG_ALPHA_ONLY   = 3'd3,
        CFG_DENS_LO      = 3'd4,
        CFG_DENS_MID     = 3'd5,
        CFG_DENS_HI      = 3'd6,
        CFG_DENS_TOP     = 3'd7
    } t_cfg_idx;

    // Pick one 7-bit density out of the packed table.
    function automatic t_dens dens_entry(logic [DENS_ALL_W-1:0] words, t_dens_idx idx);
        logic [DENS_POS_W-1:0] pos;
        pos = DENS_POS_W'(idx) * DENS_POS_W'(DENS_W);
        return words[pos +: DENS_W];
    endfunction

    // Widen a 5-bit fog channel to 6 bits by repeating its top bit.
    function automatic t_chan widen5(logic [FOG_CH_W-1:0] v);
        return {v, v[FOG_CH_W-1]};
    endfunction

endpackage

// ----- hw/rtl/depth_fog_pixel_blend.sv -----
// Depth fog blender top level: six-stage pixel pipeline and its configuration registers.
// Depends on dfpb_pkg for widths, types, register codes and helpers.

//  channel  | valid    | stall    | payload
//  ---------+----------+----------+----------------------------------------------
//  pixel in | i_valid  | o_stall  | i_fog_flag, i_depth, i_top_*, i_under_*
//  pixel out| o_valid  | i_stall  | o_out_top_*, o_out_under_*
//  config   | i_cfg_we | (none)   | i_cfg_idx, i_cfg_wdata
//
// One pixel enters per clock while o_stall is low; each result passes through six register
// stages on its way to the output: index, table lookup, interpolation products, density sum,
// blend products and output select.
// A stall on the output freezes only the stages that are full; bubbles still close up.
// Reset is synchronous and active low; it clears the stage valid bits and the
// configuration registers.

module depth_fog_pixel_blend (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_cfg_we,
    input  logic [dfpb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dfpb_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,

    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_fog_flag,
    input  logic [dfpb_pkg::DEPTH_W-1:0]       i_depth,
    input  logic [dfpb_pkg::CHAN_W-1:0]        i_top_red,
    input  logic [dfpb_pkg::CHAN_W-1:0]        i_top_green,
    input  logic [dfpb_pkg::CHAN_W-1:0]        i_top_blue,
    input  logic [dfpb_pkg::CHAN_W-1:0]        i_top_alpha,
    input  logic [dfpb_pkg::CHAN_W-1:0]        i_under_red,
    input  logic [dfpb_pkg::CHAN_W-1:0]        i_under_green,
    input  logic [dfpb_pkg::CHAN_W-1:0]        i_under_blue,
    input  logic [dfpb_pkg::CHAN_W-1:0]        i_under_alpha,

    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [dfpb_pkg::CHAN_W-1:0]        o_out_top_red,
    output logic [dfpb_pkg::CHAN_W-1:0]        o_out_top_green,
    output logic [dfpb_pkg::CHAN_W-1:0]        o_out_top_blue,
    output logic [dfpb_pkg::CHAN_W-1:0]        o_out_top_alpha,
    output logic [dfpb_pkg::CHAN_W-1:0]        o_out_under_red,
    output logic [dfpb_pkg::CHAN_W-1:0]        o_out_under_green,
    output logic [dfpb_pkg::CHAN_W-1:0]        o_out_under_blue,
    output logic [dfpb_pkg::CHAN_W-1:0]        o_out_under_alpha
);

    // Configuration registers
    logic [dfpb_pkg::FOG_COLOR_W-1:0]  r_fog_color;
    logic [dfpb_pkg::OFFSET_W-1:0]     r_depth_offset;
    logic [dfpb_pkg::SHIFT_W-1:0]      r_depth_shift;
    logic                              r_alpha_only;
    logic [dfpb_pkg::DENS_ALL_W-1:0]   r_density;

    // Stage control
    logic [dfpb_pkg::NUM_STAGES-1:0]   r_vld;
    logic [dfpb_pkg::NUM_STAGES-1:0]   stage_en;

    // Stage 1: table indexes and fraction
    logic                              r1_flag;
    dfpb_pkg::t_chan_arr               r1_chan;
    dfpb_pkg::t_dens_idx               r1_idx0;
    dfpb_pkg::t_dens_idx               r1_idx1;
    dfpb_pkg::t_frac                   r1_frac;

    // Stage 2: neighboring densities
    logic                              r2_flag;
    dfpb_pkg::t_chan_arr               r2_chan;
    dfpb_pkg::t_dens                   r2_d0;
    dfpb_pkg::t_dens                   r2_d1;
    dfpb_pkg::t_frac                   r2_frac;

    // Stage 3: interpolation products
    logic                              r3_flag;
    dfpb_pkg::t_chan_arr               r3_chan;
    logic [17:0]                       r3_p0;
    logic [17:0]                       r3_p1;

    // Stage 4: interpolated density
    logic                              r4_flag;
    dfpb_pkg::t_chan_arr               r4_chan;
    dfpb_pkg::t_dens                   r4_dens;

    // Stage 5: blend products per channel
    logic                              r5_flag;
    dfpb_pkg::t_chan_arr               r5_chan;
    logic [13:0]                       r5_pc [dfpb_pkg::NUM_CHAN];
    logic [13:0]                       r5_pf [dfpb_pkg::NUM_CHAN];

    // Stage 6: output register
    dfpb_pkg::t_chan_arr               r6_chan;

    // Combinational helpers
    dfpb_pkg::t_chan_arr               in_chan;
    logic [dfpb_pkg::OFFSET_W:0]       diff;
    logic [29:0]                       shifted;
    logic                              idx_sat;
    dfpb_pkg::t_dens_idx               idx_base;
    dfpb_pkg::t_dens_idx               n_idx0;
    dfpb_pkg::t_dens_idx               n_idx1;
    dfpb_pkg::t_frac                   n_frac;
    logic [dfpb_pkg::FRAC_W:0]         w0;
    logic [17:0]                       dens_sum;
    dfpb_pkg::t_chan                   fog_wide [4];
    logic [7:0]                        w_chan;
    dfpb_pkg::t_chan_arr               n_out;

    // Configuration writes; every index of the port names a register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fog_color    <= '0;
            r_depth_offset <= '0;
            r_depth_shift  <= '0;
            r_alpha_only   <= 1'b0;
            r_density      <= '0;
        end else if (i_cfg_we) begin
            unique case (dfpb_pkg::t_cfg_idx'(i_cfg_idx))
                dfpb_pkg::CFG_FOG_COLOR: begin
                    r_fog_color <= i_cfg_wdata[dfpb_pkg::FOG_COLOR_W-1:0];
                end
                dfpb_pkg::CFG_DEPTH_OFFSET: begin
                    r_depth_offset <= i_cfg_wdata[dfpb_pkg::OFFSET_W-1:0];
                end
                dfpb_pkg::CFG_DEPTH_SHIFT: begin
                    r_depth_shift <= i_cfg_wdata[dfpb_pkg::SHIFT_W-1:0];
                end
                dfpb_pkg::CFG_ALPHA_ONLY: begin
                    r_alpha_only <= i_cfg_wdata[0];
                end
                dfpb_pkg::CFG_DENS_LO: begin
                    r_density[0*dfpb_pkg::CFG_DATA_W +: dfpb_pkg::CFG_DATA_W] <= i_cfg_wdata;
                end
                dfpb_pkg::CFG_DENS_MID: begin
                    r_density[1*dfpb_pkg::CFG_DATA_W +: dfpb_pkg::CFG_DATA_W] <= i_cfg_wdata;
                end
                dfpb_pkg::CFG_DENS_HI: begin
                    r_density[2*dfpb_pkg::CFG_DATA_W +: dfpb_pkg::CFG_DATA_W] <= i_cfg_wdata;
                end
                dfpb_pkg::CFG_DENS_TOP: begin
                    r_density[3*dfpb_pkg::CFG_DATA_W +: dfpb_pkg::CFG_DATA_W] <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        stage_en[dfpb_pkg::NUM_STAGES-1] = !r_vld[dfpb_pkg::NUM_STAGES-1] || !i_stall;
        for (int s = dfpb_pkg::NUM_STAGES - 2; s >= 0; s--) begin
            stage_en[s] = !r_vld[s] || stage_en[s+1];
        end
    end

    assign o_stall = !stage_en[0];
    assign o_valid = r_vld[dfpb_pkg::NUM_STAGES-1];

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < dfpb_pkg::NUM_STAGES; s++) begin
                if (stage_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // Gather the input channels: top layer in lanes 0-3, second layer in lanes 4-7.
    always_comb begin
        in_chan[0] = i_top_red;
        in_chan[1] = i_top_green;
        in_chan[2] = i_top_blue;
        in_chan[3] = i_top_alpha;
        in_chan[4] = i_under_red;
        in_chan[5] = i_under_green;
        in_chan[6] = i_under_blue;
        in_chan[7] = i_under_alpha;
    end

    // Stage 1 logic: scale and correct the depth, then form both neighbor indexes.
    // A negative corrected depth selects entry 0 for both neighbors.
    always_comb begin
        diff = {1'b0, i_depth[dfpb_pkg::DEPTH_W-1:dfpb_pkg::DEPTH_SCALE]}
             - {1'b0, r_depth_offset};
        shifted  = 30'(diff[dfpb_pkg::OFFSET_W-1:0]) << r_depth_shift;
        idx_sat  = |shifted[29:15];
        idx_base = shifted[14:10];
        n_frac   = shifted[dfpb_pkg::FRAC_W-1:0];
        if (diff[dfpb_pkg::OFFSET_W]) begin
            n_idx0 = '0;
            n_idx1 = '0;
        end else if (idx_sat) begin
            n_idx0 = '1;
            n_idx1 = '1;
        end else begin
            n_idx0 = idx_base;
            n_idx1 = (&idx_base) ? idx_base : idx_base + 1'b1;
        end
    end

    // Stage 3 logic: weight of the lower neighbor.
    assign w0 = (dfpb_pkg::FRAC_W+1)'(1 << dfpb_pkg::FRAC_W) - {1'b0, r2_frac};

    // Stage 4 logic: sum of the two weighted densities, scaled back down.
    assign dens_sum = r3_p0 + r3_p1;

    // Fog color channels widened to 6 bits.
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            fog_wide[j] = dfpb_pkg::widen5(r_fog_color[j*dfpb_pkg::FOG_CH_W +: dfpb_pkg::FOG_CH_W]);
        end
        w_chan = 8'(1 << dfpb_pkg::DENS_W) - {1'b0, r4_dens};
    end

    // Stage 6 logic: keep the original channel unless it is fogged.
    always_comb begin
        logic [13:0] s;
        logic        lane_alpha;
        for (int k = 0; k < dfpb_pkg::NUM_CHAN; k++) begin
            s          = r5_pc[k] + r5_pf[k];
            lane_alpha = (2'(k) == dfpb_pkg::ALPHA_LANE);
            if (r5_flag && (lane_alpha || !r_alpha_only)) begin
                n_out[k] = s[12:7];
            end else begin
                n_out[k] = r5_chan[k];
            end
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r1_flag <= i_fog_flag;
            r1_chan <= in_chan;
            r1_idx0 <= n_idx0;
            r1_idx1 <= n_idx1;
            r1_frac <= n_frac;
        end
        if (stage_en[1]) begin
            r2_flag <= r1_flag;
            r2_chan <= r1_chan;
            r2_d0   <= dfpb_pkg::dens_entry(r_density, r1_idx0);
            r2_d1   <= dfpb_pkg::dens_entry(r_density, r1_idx1);
            r2_frac <= r1_frac;
        end
        if (stage_en[2]) begin
            r3_flag <= r2_flag;
            r3_chan <= r2_chan;
            r3_p0   <= 18'(r2_d0) * 18'(w0);
            r3_p1   <= 18'(r2_d1) * 18'(r2_frac);
        end
        if (stage_en[3]) begin
            r4_flag <= r3_flag;
            r4_chan <= r3_chan;
            r4_dens <= dens_sum[16:10];
        end
        if (stage_en[4]) begin
            r5_flag <= r4_flag;
            r5_chan <= r4_chan;
            for (int k = 0; k < dfpb_pkg::NUM_CHAN; k++) begin
                r5_pc[k] <= 14'(r4_chan[k]) * 14'(w_chan);
                r5_pf[k] <= 14'(fog_wide[k % 4]) * 14'(r4_dens);
            end
        end
        if (stage_en[5]) begin
            r6_chan <= n_out;
        end
    end

    // Result ports.
    assign o_out_top_red     = r6_chan[0];
    assign o_out_top_green   = r6_chan[1];
    assign o_out_top_blue    = r6_chan[2];
    assign o_out_top_alpha   = r6_chan[3];
    assign o_out_under_red   = r6_chan[4];
    assign o_out_under_green = r6_chan[5];
    assign o_out_under_blue  = r6_chan[6];
    assign o_out_under_alpha = r6_chan[7];

endmodule
